// ----- rtl/mdh_pkg.sv -----
// ----------------------------------------------------------------------------
// mdh_pkg
// Shared types, register indexes, reset values and helpers for the
// debounced motion detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mdh_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_ENABLE       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACCEL_REF_SQ = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACCEL_THR    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GYRO_THR     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_NEED  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_STILL_NEED   = 3'd5;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned AxisW    = 16;
  localparam int unsigned MagW     = AxisW + 1;
  localparam int unsigned RunW     = 4;

  // Reset values
  localparam logic [31:0]     RST_ACCEL_REF_SQ = 32'd0;
  localparam logic [31:0]     RST_ACCEL_THR    = 32'd40000000;
  localparam logic [15:0]     RST_GYRO_THR     = 16'd655;
  localparam logic [RunW-1:0] RST_ACTIVE_NEED  = 4'd2;
  localparam logic [RunW-1:0] RST_STILL_NEED   = 4'd10;

  typedef enum logic [1:0] {
    TRANS_NONE           = 2'd0,
    TRANS_BECAME_MOVING  = 2'd1,
    TRANS_BECAME_STOPPED = 2'd2
  } trans_e;

  typedef struct packed {
    logic            enable;
    logic [31:0]     accel_ref_sq;
    logic [31:0]     accel_thr;
    logic [15:0]     gyro_thr;
    logic [RunW-1:0] active_need;
    logic [RunW-1:0] still_need;
  } cfg_t;

  typedef struct packed {
    logic   moving;
    trans_e transition;
    logic   sample_active;
  } res_t;

  // Magnitude of a two's complement axis; -32768 maps to 32768.
  function automatic logic [MagW-1:0] mag16(input logic [AxisW-1:0] raw);
    logic [MagW-1:0] ext;
    ext = {raw[AxisW-1], raw};
    return raw[AxisW-1] ? (MagW'(0) - ext) : ext;
  endfunction

endpackage

// ----- rtl/motion_detect_hysteresis.sv -----
// ----------------------------------------------------------------------------
// motion_detect_hysteresis
// A sample passes through the input register, then the result register;
//   throughput: one sample per cycle while out_ready_i does not stall the
//   result register, with the debounce state update between the two
//   registers.
// Reset: asynchronous, active low; clears both stages, the motion state and
//   loads the configuration reset values (detection disabled).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motion_detect_hysteresis (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mdh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mdh_pkg::CfgDataW-1:0] cfg_data_i,
  // sample input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mdh_pkg::AxisW-1:0]    accel_x_i,
  input  logic [mdh_pkg::AxisW-1:0]    accel_y_i,
  input  logic [mdh_pkg::AxisW-1:0]    accel_z_i,
  input  logic [mdh_pkg::AxisW-1:0]    gyro_x_i,
  input  logic [mdh_pkg::AxisW-1:0]    gyro_y_i,
  input  logic [mdh_pkg::AxisW-1:0]    gyro_z_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         moving_o,
  output logic [1:0]                   transition_o,
  output logic                         sample_active_o
);

  mdh_pkg::cfg_t cfg;
  logic          clear;

  // Stage 1: input register. Holds one sample transfer.
  logic                      s1_valid_q;
  logic [mdh_pkg::AxisW-1:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;

  // Stage 2: result register.
  logic          out_valid_q;
  mdh_pkg::res_t res_q, res_d;

  logic active;
  logic advance;  // sample moves from stage 1 into the result register

  mdh_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .clear_o     (clear)
  );

  // Result register frees up when empty or when its transfer completes;
  // stage 1 refills in the same cycle it drains, so no bubble.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      az_q <= accel_z_i;
      gx_q <= gyro_x_i;
      gy_q <= gyro_y_i;
      gz_q <= gyro_z_i;
    end
  end

  mdh_classify u_classify (
    .accel_x_i (ax_q),
    .accel_y_i (ay_q),
    .accel_z_i (az_q),
    .gyro_x_i  (gx_q),
    .gyro_y_i  (gy_q),
    .gyro_z_i  (gz_q),
    .cfg_i     (cfg),
    .active_o  (active)
  );

  // Motion state commits only on advance, so results keep sample order.
  mdh_debounce u_debounce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .clear_i  (clear),
    .step_i   (advance),
    .active_i (active),
    .res_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign moving_o        = res_q.moving;
  assign transition_o    = res_q.transition;
  assign sample_active_o = res_q.sample_active;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_moving_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (transition_o == mdh_pkg::TRANS_BECAME_MOVING)
      |-> moving_o && sample_active_o)
    else $error("became-moving result without active sample or flag");

  a_stopped_needs_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (transition_o == mdh_pkg::TRANS_BECAME_STOPPED)
      |-> !moving_o && !sample_active_o)
    else $error("became-stopped result with active sample or flag");

  a_no_bad_transition: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (transition_o != 2'd3))
    else $error("undefined transition code");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && s1_valid_q)
    else $error("input stalled while pipeline can move");

endmodule

// ----- rtl/mdh_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mdh_cfg_regs
// Configuration register file; flags a state clear when enable is set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdh_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mdh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mdh_pkg::CfgDataW-1:0] cfg_data_i,
  output mdh_pkg::cfg_t                cfg_o,
  output logic                         clear_o
);

  mdh_pkg::cfg_t cfg_q, cfg_d;
  logic          clear_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d   = cfg_q;
    clear_d = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mdh_pkg::CFG_ENABLE: begin
          cfg_d.enable = cfg_data_i[0];
          clear_d      = cfg_data_i[0];
        end
        mdh_pkg::CFG_ACCEL_REF_SQ: cfg_d.accel_ref_sq = cfg_data_i;
        mdh_pkg::CFG_ACCEL_THR:    cfg_d.accel_thr    = cfg_data_i;
        mdh_pkg::CFG_GYRO_THR:     cfg_d.gyro_thr     = cfg_data_i[15:0];
        mdh_pkg::CFG_ACTIVE_NEED:  cfg_d.active_need  = cfg_data_i[mdh_pkg::RunW-1:0];
        mdh_pkg::CFG_STILL_NEED:   cfg_d.still_need   = cfg_data_i[mdh_pkg::RunW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable       <= 1'b0;
      cfg_q.accel_ref_sq <= mdh_pkg::RST_ACCEL_REF_SQ;
      cfg_q.accel_thr    <= mdh_pkg::RST_ACCEL_THR;
      cfg_q.gyro_thr     <= mdh_pkg::RST_GYRO_THR;
      cfg_q.active_need  <= mdh_pkg::RST_ACTIVE_NEED;
      cfg_q.still_need   <= mdh_pkg::RST_STILL_NEED;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o   = cfg_q;
  assign clear_o = clear_d;

endmodule

// ----- rtl/mdh_classify.sv -----
// ----------------------------------------------------------------------------
// mdh_classify
// Flags a sample as active from accel magnitude deviation or gyro rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdh_classify (
  input  logic [mdh_pkg::AxisW-1:0] accel_x_i,
  input  logic [mdh_pkg::AxisW-1:0] accel_y_i,
  input  logic [mdh_pkg::AxisW-1:0] accel_z_i,
  input  logic [mdh_pkg::AxisW-1:0] gyro_x_i,
  input  logic [mdh_pkg::AxisW-1:0] gyro_y_i,
  input  logic [mdh_pkg::AxisW-1:0] gyro_z_i,
  input  mdh_pkg::cfg_t             cfg_i,
  output logic                      active_o
);

  logic [mdh_pkg::MagW-1:0]   ax, ay, az, gx, gy, gz;
  logic [2*mdh_pkg::MagW-1:0] sq_x, sq_y, sq_z;
  logic [31:0]                sq_sum, diff;
  logic [mdh_pkg::MagW-1:0]   gthr;
  logic                       accel_hit, gyro_hit;

  assign ax = mdh_pkg::mag16(accel_x_i);
  assign ay = mdh_pkg::mag16(accel_y_i);
  assign az = mdh_pkg::mag16(accel_z_i);
  assign gx = mdh_pkg::mag16(gyro_x_i);
  assign gy = mdh_pkg::mag16(gyro_y_i);
  assign gz = mdh_pkg::mag16(gyro_z_i);

  // Each square is at most 2^30, so the sum fits 32 bits.
  assign sq_x   = ax * ax;
  assign sq_y   = ay * ay;
  assign sq_z   = az * az;
  assign sq_sum = {1'b0, sq_x[30:0]} + {1'b0, sq_y[30:0]} + {1'b0, sq_z[30:0]};

  assign diff = (sq_sum >= cfg_i.accel_ref_sq) ? (sq_sum - cfg_i.accel_ref_sq)
                                               : (cfg_i.accel_ref_sq - sq_sum);

  assign gthr      = {1'b0, cfg_i.gyro_thr};
  assign accel_hit = diff > cfg_i.accel_thr;
  assign gyro_hit  = (gx > gthr) || (gy > gthr) || (gz > gthr);
  assign active_o  = accel_hit || gyro_hit;

endmodule

// ----- rtl/mdh_debounce.sv -----
// ----------------------------------------------------------------------------
// mdh_debounce
// Run counters and moving flag with hysteresis; yields the per-sample result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdh_debounce (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mdh_pkg::cfg_t cfg_i,
  input  logic          clear_i,
  input  logic          step_i,
  input  logic          active_i,
  output mdh_pkg::res_t res_o
);

  logic                     moving_q, moving_d;
  logic [mdh_pkg::RunW-1:0] active_run_q, active_run_d;
  logic [mdh_pkg::RunW-1:0] still_run_q, still_run_d;
  mdh_pkg::trans_e          trans;

  always_comb begin
    moving_d     = moving_q;
    active_run_d = active_run_q;
    still_run_d  = still_run_q;
    trans        = mdh_pkg::TRANS_NONE;
    if (cfg_i.enable) begin
      if (active_i) begin
        still_run_d = '0;
        if (active_run_q < cfg_i.active_need) active_run_d = active_run_q + 1'b1;
        if (!moving_q && (active_run_d >= cfg_i.active_need)) begin
          moving_d = 1'b1;
          trans    = mdh_pkg::TRANS_BECAME_MOVING;
        end
      end else begin
        active_run_d = '0;
        if (still_run_q < cfg_i.still_need) still_run_d = still_run_q + 1'b1;
        if (moving_q && (still_run_d >= cfg_i.still_need)) begin
          moving_d = 1'b0;
          trans    = mdh_pkg::TRANS_BECAME_STOPPED;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moving_q     <= 1'b0;
      active_run_q <= '0;
      still_run_q  <= '0;
    end else if (clear_i) begin
      moving_q     <= 1'b0;
      active_run_q <= '0;
      still_run_q  <= '0;
    end else if (step_i) begin
      moving_q     <= moving_d;
      active_run_q <= active_run_d;
      still_run_q  <= still_run_d;
    end
  end

  assign res_o.moving        = moving_d;
  assign res_o.transition    = trans;
  assign res_o.sample_active = cfg_i.enable & active_i;

endmodule
